// ===== src/llts_pkg.sv =====
// Shared types, codes and compare function for the least-laxity task scheduler.
`timescale 1ns / 1ps

package llts_pkg;

    // Slots held by one cell of the search chain
    localparam int LANES    = 8;
    localparam int LANE_W   = 3;
    localparam int TIME_W   = 24;
    localparam int DL_W     = 16;
    localparam int KEY_W    = DL_W + 1;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Input operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kind codes
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_RUN  = 2'd1;
    localparam logic [1:0] KIND_IDLE = 2'd2;

    typedef struct packed {
        logic            op;
        logic [5:0]      task_slot;
        logic [DL_W-1:0] deadline;
        logic [DL_W-1:0] length;
    } llts_in_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [5:0]        chosen_slot;
        logic              finished;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] overshoot;
    } llts_out_t;

    // Candidate handed along the chain; key is deadline minus remaining
    // (current time is common to all slots, so it drops out of the compare)
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [DL_W-1:0]         deadline;
        logic [DL_W-1:0]         remaining;
    } llts_cand_t;

    // Broadcast command from the sequencer to every cell
    typedef struct packed {
        logic              wr_en;
        logic              dec_en;
        logic [LANE_W-1:0] lane;
        logic [DL_W-1:0]   deadline;
        logic [DL_W-1:0]   length;
    } llts_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } llts_state_t;

    // True when a is strictly better than b
    function automatic logic cand_beats(llts_cand_t a, llts_cand_t b);
        logic lt;
        logic eq;
        lt = $signed(a.key) < $signed(b.key);
        eq = $signed(a.key) == $signed(b.key);
        return a.valid && (!b.valid || lt || (eq && (a.deadline < b.deadline)));
    endfunction

endpackage

// ===== src/llts_cell.sv =====
// One cell of the search chain: eight task slots plus a registered best candidate.
`timescale 1ns / 1ps

module llts_cell #(
    parameter int SLOT_W     = 6,
    parameter int CELL_INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  llts_pkg::llts_cmd_t  cmd,
    input  logic                 hit,
    input  llts_pkg::llts_cand_t cand_in,
    input  logic [SLOT_W-1:0]    slot_in,
    output llts_pkg::llts_cand_t cand_out,
    output logic [SLOT_W-1:0]    slot_out
);
    import llts_pkg::*;

    localparam logic [SLOT_W-1:0] BASE = SLOT_W'(CELL_INDEX * LANES);

    logic [DL_W-1:0]   dl_reg  [LANES];
    logic [DL_W-1:0]   rem_reg [LANES];
    llts_cand_t        cand_out_reg;
    logic [SLOT_W-1:0] slot_out_reg;

    llts_cand_t        lc   [LANES];
    llts_cand_t        l1   [LANES/2];
    logic [LANE_W-1:0] l1_n [LANES/2];
    llts_cand_t        l2   [LANES/4];
    logic [LANE_W-1:0] l2_n [LANES/4];
    llts_cand_t        loc;
    logic [LANE_W-1:0] loc_n;

    // Deadlines: written by loads only, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && hit)
        begin
            dl_reg[cmd.lane] <= cmd.deadline;
        end
    end

    // Remaining lengths: cleared at reset, written by loads, decremented by ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                rem_reg[j] <= '0;
            end
        end
        else if (cmd.wr_en && hit)
        begin
            rem_reg[cmd.lane] <= cmd.length;
        end
        else if (cmd.dec_en && hit)
        begin
            rem_reg[cmd.lane] <= rem_reg[cmd.lane] - 1'b1;
        end
    end

    // Local best over the eight lanes; lower lane wins a full tie
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            lc[j].valid     = (rem_reg[j] != '0);
            lc[j].key       = $signed({1'b0, dl_reg[j]}) - $signed({1'b0, rem_reg[j]});
            lc[j].deadline  = dl_reg[j];
            lc[j].remaining = rem_reg[j];
        end
        for (int j = 0; j < LANES/2; j++)
        begin
            if (cand_beats(lc[2*j+1], lc[2*j]))
            begin
                l1[j]   = lc[2*j+1];
                l1_n[j] = LANE_W'(2*j+1);
            end
            else
            begin
                l1[j]   = lc[2*j];
                l1_n[j] = LANE_W'(2*j);
            end
        end
        for (int j = 0; j < LANES/4; j++)
        begin
            if (cand_beats(l1[2*j+1], l1[2*j]))
            begin
                l2[j]   = l1[2*j+1];
                l2_n[j] = l1_n[2*j+1];
            end
            else
            begin
                l2[j]   = l1[2*j];
                l2_n[j] = l1_n[2*j];
            end
        end
        if (cand_beats(l2[1], l2[0]))
        begin
            loc   = l2[1];
            loc_n = l2_n[1];
        end
        else
        begin
            loc   = l2[0];
            loc_n = l2_n[0];
        end
    end

    // Merge with the neighbor's candidate; incoming holds lower slots, so it wins ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_out_reg <= '0;
            slot_out_reg <= '0;
        end
        else if (cand_beats(loc, cand_in))
        begin
            cand_out_reg <= loc;
            slot_out_reg <= BASE + SLOT_W'(loc_n);
        end
        else
        begin
            cand_out_reg <= cand_in;
            slot_out_reg <= slot_in;
        end
    end

    assign cand_out = cand_out_reg;
    assign slot_out = slot_out_reg;

endmodule

// ===== src/least_laxity_task_scheduler.sv =====
// Top level: least-laxity-first scheduler built on a chain of slot cells.
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+---------------------------
//  item    | item_valid / item_ready / item   | in        | op, task_slot, deadline, length
//  result  | result_valid / result_ready / result | out   | kind, chosen_slot, finished,
//          |                                  |           | finish_time, overshoot
//
// A load item passes through the idle and done states. A tick item adds a search state that spans the chain:
// the best candidate moves one cell (eight slots) per cycle along the chain.
// One item is worked at a time; the next is taken while the last result waits.
// Reset clears all remaining lengths and the time; deadlines hold garbage until loaded.
// A stalled result holds in the output register and blocks only the handoff stage.
`timescale 1ns / 1ps

module least_laxity_task_scheduler #(
    parameter int TASK_SLOTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  llts_pkg::llts_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output llts_pkg::llts_out_t result
);
    import llts_pkg::*;

    localparam int NCELLS = (TASK_SLOTS + LANES - 1) / LANES;
    localparam int SLOT_W = $clog2(NCELLS * LANES);
    localparam int CNT_W  = $clog2(NCELLS + 1);

    llts_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_inc;
    llts_out_t         res_reg;
    llts_out_t         res_next;
    llts_out_t         out_reg;
    logic              out_valid_reg;

    llts_cand_t        chain_cand [NCELLS+1];
    logic [SLOT_W-1:0] chain_slot [NCELLS+1];
    llts_cand_t        best;
    logic [SLOT_W-1:0] best_slot;

    llts_cmd_t         cmd;
    logic [SLOT_W-1:0] tgt;
    logic [NCELLS-1:0] cell_hit;
    logic              accept;
    logic              load_ok;
    logic              search_done;
    logic              push;
    logic [TIME_W-1:0] dl_ext;

    assign accept      = item_valid && item_ready;
    assign best        = chain_cand[NCELLS];
    assign best_slot   = chain_slot[NCELLS];
    assign search_done = (state_reg == ST_SEARCH) && (cnt_reg == CNT_W'(NCELLS));
    assign push        = (state_reg == ST_DONE) && (!out_valid_reg || result_ready);
    assign load_ok     = (int'(item.task_slot) < TASK_SLOTS);
    assign time_inc    = (time_reg == TIME_MAX) ? time_reg : time_reg + 1'b1;
    assign dl_ext      = TIME_W'(best.deadline);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and cell commands
    always_comb
    begin
        state_next   = state_reg;
        item_ready   = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.dec_en   = 1'b0;
        cmd.deadline = item.deadline;
        cmd.length   = item.length;
        tgt          = best_slot;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                tgt        = SLOT_W'(item.task_slot);
                if (item_valid)
                begin
                    if (item.op == OP_LOAD)
                    begin
                        cmd.wr_en  = load_ok;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (search_done)
                begin
                    cmd.dec_en = best.valid;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (push)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.lane = tgt[LANE_W-1:0];
    end

    // Cell select from the slot's upper bits
    always_comb
    begin
        for (int i = 0; i < NCELLS; i++)
        begin
            cell_hit[i] = ((tgt >> LANE_W) == SLOT_W'(i));
        end
    end

    // Chain of cells; the candidate enters empty at cell 0
    assign chain_cand[0] = '0;
    assign chain_slot[0] = '0;

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        llts_cell #(
            .SLOT_W     (SLOT_W),
            .CELL_INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .hit      (cell_hit[i]),
            .cand_in  (chain_cand[i]),
            .slot_in  (chain_slot[i]),
            .cand_out (chain_cand[i+1]),
            .slot_out (chain_slot[i+1])
        );
    end

    // Search counter and time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            time_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_SEARCH && !search_done)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (search_done && best.valid)
            begin
                time_reg <= time_inc;
            end
        end
    end

    // Result of the item in work: zero on accept, filled in when the search ends
    always_comb
    begin
        res_next = '0;
        if (search_done)
        begin
            if (best.valid)
            begin
                res_next.kind        = KIND_RUN;
                res_next.chosen_slot = 6'(best_slot);
                if (best.remaining == DL_W'(1))
                begin
                    res_next.finished    = 1'b1;
                    res_next.finish_time = time_inc;
                    res_next.overshoot   = (time_inc > dl_ext) ? time_inc - dl_ext : '0;
                end
            end
            else
            begin
                res_next.kind = KIND_IDLE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept || search_done)
        begin
            res_reg <= res_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= res_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Time moves by one (or holds at max) on a scheduling tick
    a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
        (search_done && best.valid) |=>
            ($past(time_reg) == TIME_MAX) || (time_reg == $past(time_reg) + 1'b1))
        else $error("time did not advance on a scheduling tick");

    // An idle tick leaves time alone
    a_idle_time: assert property (@(posedge clk) disable iff (!rst_n)
        (search_done && !best.valid) |=> $stable(time_reg))
        else $error("time moved on an idle tick");

    // Only scheduling ticks report a finish
    a_finish_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.finished) |-> (out_reg.kind == KIND_RUN))
        else $error("finish flagged on a non-scheduling result");

    // Overshoot never exceeds finish time
    a_overshoot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.overshoot <= out_reg.finish_time))
        else $error("overshoot larger than finish time");

    // Search always runs the full chain length before reporting
    a_search_len: assert property (@(posedge clk) disable iff (!rst_n)
        search_done |-> (cnt_reg == CNT_W'(NCELLS)) && (state_reg == ST_SEARCH))
        else $error("search ended early");

endmodule

// ===== tb/tb_least_laxity_task_scheduler.sv =====
// Self-checking testbench for the least-laxity task scheduler: directed cases, then random bursts.
`timescale 1ns / 1ps

module tb_least_laxity_task_scheduler;
    import llts_pkg::*;

    // Tracks slot deadlines, remaining lengths and time; predicts one result per item
    class laxity_tracker;
        logic [DL_W-1:0]   slot_dl [64];
        logic [DL_W-1:0]   slot_rem [64];
        logic [TIME_W-1:0] now;
        llts_out_t         pending_results[$];
        int                mismatches;

        function new();
            for (int s = 0; s < 64; s++)
            begin
                slot_dl[s]  = '0;
                slot_rem[s] = '0;
            end
            now        = '0;
            mismatches = 0;
        endfunction

        // Apply an accepted item to the tracked state and queue its result
        function void note_item(llts_in_t it);
            llts_out_t r;
            longint    lax;
            longint    best_lax;
            int        best;
            bit        found;
            r        = '0;
            best     = 0;
            best_lax = 0;
            found    = 0;
            if (it.op == OP_LOAD)
            begin
                slot_dl[it.task_slot]  = it.deadline;
                slot_rem[it.task_slot] = it.length;
                r.kind = KIND_LOAD;
            end
            else
            begin
                // Least laxity wins; ties go to the earlier deadline, then the lower slot
                for (int s = 0; s < 64; s++)
                begin
                    if (slot_rem[s] != 0)
                    begin
                        lax = longint'(slot_dl[s]) - longint'(now) - longint'(slot_rem[s]);
                        if (!found || lax < best_lax ||
                            (lax == best_lax && slot_dl[s] < slot_dl[best]))
                        begin
                            found    = 1;
                            best     = s;
                            best_lax = lax;
                        end
                    end
                end
                if (!found)
                    r.kind = KIND_IDLE;
                else
                begin
                    slot_rem[best] = slot_rem[best] - 1'b1;
                    if (now != TIME_MAX)
                        now = now + 1'b1;
                    r.kind        = KIND_RUN;
                    r.chosen_slot = best[5:0];
                    if (slot_rem[best] == 0)
                    begin
                        r.finished    = 1'b1;
                        r.finish_time = now;
                        r.overshoot   = (now > TIME_W'(slot_dl[best])) ?
                                        now - TIME_W'(slot_dl[best]) : '0;
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        // Compare one result against the oldest expectation, field by field
        function void check_result(llts_out_t act);
            llts_out_t exp_r;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual kind %0d slot %0d",
                         $realtime, act.kind, act.chosen_slot);
                mismatches++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (act.kind !== exp_r.kind)
            begin
                $display("%0t: kind expected %0d actual %0d", $realtime, exp_r.kind, act.kind);
                mismatches++;
            end
            if (act.chosen_slot !== exp_r.chosen_slot)
            begin
                $display("%0t: chosen_slot expected %0d actual %0d",
                         $realtime, exp_r.chosen_slot, act.chosen_slot);
                mismatches++;
            end
            if (act.finished !== exp_r.finished)
            begin
                $display("%0t: finished expected %0d actual %0d",
                         $realtime, exp_r.finished, act.finished);
                mismatches++;
            end
            if (act.finish_time !== exp_r.finish_time)
            begin
                $display("%0t: finish_time expected %0d actual %0d",
                         $realtime, exp_r.finish_time, act.finish_time);
                mismatches++;
            end
            if (act.overshoot !== exp_r.overshoot)
            begin
                $display("%0t: overshoot expected %0d actual %0d",
                         $realtime, exp_r.overshoot, act.overshoot);
                mismatches++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 600000;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    llts_in_t  item;
    logic      result_valid;
    logic      result_ready;
    llts_out_t result;

    laxity_tracker tracker;
    int            items_sent;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            cycles;

    least_laxity_task_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver back-pressure, changed on the falling edge
    always @(negedge clk)
        result_ready = ($urandom_range(0, 99) >= recv_stall_pct);

    // Result monitor
    always @(posedge clk)
        if (rst_n && result_valid && result_ready)
            tracker.check_result(result);

    // Present one item, with random gaps ahead of it, and hold until taken
    task automatic send_item(input llts_in_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item       = it;
        item_valid = 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        tracker.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic load(input int slot, input int dl, input int len);
        llts_in_t it;
        it.op        = OP_LOAD;
        it.task_slot = 6'(slot);
        it.deadline  = 16'(dl);
        it.length    = 16'(len);
        send_item(it);
    endtask

    // Tick with random content in the ignored fields
    task automatic tick();
        llts_in_t it;
        it.op        = OP_TICK;
        it.task_slot = 6'($urandom);
        it.deadline  = 16'($urandom);
        it.length    = 16'($urandom);
        send_item(it);
    endtask

    // Random load: deadlines mostly near the current time so laxities collide
    task automatic rand_load();
        int dl;
        int len;
        int pick;
        pick = $urandom_range(0, 31);
        if (pick < 4)
            dl = $urandom_range(0, 65535);
        else
            dl = int'(tracker.now) + $urandom_range(0, 40);
        pick = $urandom_range(0, 31);
        if (pick == 0)
            len = 0;
        else if (pick == 1)
            len = $urandom_range(0, 65535);
        else
            len = $urandom_range(1, 6);
        load($urandom_range(0, 63), dl, len);
    endtask

    // Bursts of loads followed by ticks and now and then a random item; long tasks are flushed so others can finish
    task automatic run_bursts(input int n_items);
        int       stop_at;
        llts_in_t junk;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            repeat ($urandom_range(1, 6)) rand_load();
            repeat ($urandom_range(1, 16)) tick();
            if ($urandom_range(0, 9) == 0)
            begin
                junk.op        = 1'($urandom);
                junk.task_slot = 6'($urandom);
                junk.deadline  = 16'($urandom);
                junk.length    = 16'($urandom);
                send_item(junk);
            end
            for (int s = 0; s < 64; s++)
                if (tracker.slot_rem[s] > 64)
                    load(s, $urandom_range(0, 65535), 0);
        end
    endtask

    initial
    begin
        tracker        = new();
        items_sent     = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        result_ready   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty ticks, emptying load, extremes, ties, overshoot
        tick();
        load(0, 0, 0);
        tick();
        load(63, 65535, 65535);
        load(5, 3, 2);
        tick();
        load(63, 0, 0);
        tick();
        tick();
        load(10, 20, 2);
        load(3, 20, 2);
        load(7, 21, 3);
        tick();
        tick();
        tick();
        load(1, 0, 1);
        tick();
        load(42, 16'haaaa, 16'h5555);
        load(21, 16'h5555, 16'haaaa);
        load(42, 16'hffff, 0);
        load(21, 0, 0);
        repeat (5) tick();

        // Random part over the four idling phases
        run_bursts(480);
        send_idle_pct = 59;
        run_bursts(480);
        send_idle_pct  = 0;
        recv_stall_pct = 59;
        run_bursts(480);
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        run_bursts(480);
        item_valid = 1'b0;

        // Drain, then let the pipeline settle
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/llts_pkg.sv
src/llts_cell.sv
src/least_laxity_task_scheduler.sv
tb/tb_least_laxity_task_scheduler.sv
